// ===== hw/rtl/fifo_tlb_lookup_update_core_assert.svh =====
// assertion macros for the translation buffer checker
// expects signals named clk and rst in the scope of each use
`ifndef FIFO_TLB_LOOKUP_UPDATE_CORE_ASSERT_SVH
`define FIFO_TLB_LOOKUP_UPDATE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FTLB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ftlb check failed");

// next-cycle implication, checked outside reset
`define FTLB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ftlb check failed");

`endif

// ===== hw/rtl/ftlb_pkg.sv =====
// shared types and constants of the translation buffer
// no dependencies
package ftlb_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 20;
  localparam int FRAME_BITS_DEF = 16;
  localparam int CFG_W          = 5;
  localparam int TOTAL_W        = 32;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  // operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_ENCODE,
    ST_APPLY,
    ST_FINISH
  } ftlb_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic compare;
    logic encode;
    logic apply;
    logic finish;
  } ftlb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } ftlb_status_t;

endpackage

// ===== hw/rtl/ftlb_ctrl.sv =====
// sequencer of the translation buffer: one item through compare, encode, apply, finish
// depends on ftlb_pkg
module ftlb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ftlb_pkg::ftlb_status_t status,
  output ftlb_pkg::ftlb_cmd_t    cmd
);
  import ftlb_pkg::*;

  ftlb_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_COMPARE;
      ST_COMPARE: state_next = ST_ENCODE;
      ST_ENCODE:  state_next = ST_APPLY;
      ST_APPLY:   state_next = ST_FINISH;
      ST_FINISH:  if (status.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_COMPARE: cmd.compare = 1'b1;
      ST_ENCODE:  cmd.encode  = 1'b1;
      ST_APPLY:   cmd.apply   = 1'b1;
      ST_FINISH:  cmd.finish  = status.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/ftlb_datapath.sv =====
// entry store, tag compare, fifo ring, counters and output register
// depends on ftlb_pkg
module ftlb_datapath #(
  parameter int ENTRIES    = ftlb_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = ftlb_pkg::KEY_BITS_DEF,
  parameter int FRAME_BITS = ftlb_pkg::FRAME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ftlb_pkg::ftlb_cmd_t          cmd,
  output ftlb_pkg::ftlb_status_t       status,
  input  logic                         operation,
  input  logic [KEY_BITS-1:0]          logical_address,
  input  logic [FRAME_BITS-1:0]        frame_number,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ftlb_pkg::CFG_W-1:0]   cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic [FRAME_BITS-1:0]        found_frame,
  output logic                         evicted,
  output logic [ftlb_pkg::TOTAL_W-1:0] hit_total,
  output logic [ftlb_pkg::TOTAL_W-1:0] miss_total
);
  import ftlb_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // latched request
  logic                  req_op;
  logic [KEY_BITS-1:0]   req_key;
  logic [FRAME_BITS-1:0] req_frame;

  // entry store
  logic [KEY_BITS-1:0]   entry_key [ENTRIES];
  logic [FRAME_BITS-1:0] frame_mem [ENTRIES];
  logic [ENTRIES-1:0]    entry_valid;
  logic [IDX_W-1:0]      oldest_slot;
  logic [CNT_W-1:0]      occupancy;
  logic [TOTAL_W-1:0]    hit_counter;
  logic [TOTAL_W-1:0]    miss_counter;
  logic [CFG_W-1:0]      active_entries;

  // per-item working registers
  logic [ENTRIES-1:0]    match_vec;
  logic                  hit_any;
  logic [IDX_W-1:0]      hit_slot;
  logic [FRAME_BITS-1:0] frame_rd;
  logic                  res_evicted;

  logic [ENTRIES-1:0]    match_c;
  logic                  hit_any_c;
  logic [IDX_W-1:0]      hit_slot_c;
  logic [CNT_W-1:0]      limit;
  logic                  insert_new;
  logic                  evict_c;
  logic [IDX_W-1:0]      oldest_inc;
  logic [IDX_W-1:0]      oldest_next;
  logic [CNT_W-1:0]      occ_after;
  logic [CNT_W:0]        pos_sum;
  logic [IDX_W-1:0]      pos;
  logic [ENTRIES-1:0]    valid_next;

  assign cfg_ready       = 1'b1;
  assign status.out_free = !out_valid || out_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= ACTIVE_RESET;
    end else if (cfg_valid) begin
      active_entries <= cfg_data;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op    <= operation;
      req_key   <= logical_address;
      req_frame <= frame_number;
    end
  end

  // tag compare against every entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_c[i] = entry_valid[i] && (entry_key[i] == req_key);
    end
  end

  // present keys are unique, so at most one match bit is set
  always_comb begin
    hit_slot_c = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) hit_slot_c = hit_slot_c | IDX_W'(i);
    end
  end
  assign hit_any_c = |match_vec;

  always_ff @(posedge clk) begin
    if (cmd.compare) match_vec <= match_c;
    if (cmd.encode) begin
      hit_any  <= hit_any_c;
      hit_slot <= hit_slot_c;
    end
  end

  // effective limit: zero acts as one, above depth acts as depth
  always_comb begin
    if (active_entries == '0) begin
      limit = CNT_W'(1);
    end else if (32'(active_entries) > ENTRIES) begin
      limit = CNT_W'(ENTRIES);
    end else begin
      limit = CNT_W'(active_entries);
    end
  end

  // ring arithmetic for an insert of a new key
  assign insert_new  = (req_op == OP_INSERT) && !hit_any;
  assign evict_c     = insert_new && (occupancy >= limit);
  assign oldest_inc  = (32'(oldest_slot) == ENTRIES - 1) ? '0 : oldest_slot + IDX_W'(1);
  assign oldest_next = evict_c ? oldest_inc : oldest_slot;
  assign occ_after   = evict_c ? occupancy - CNT_W'(1) : occupancy;

  always_comb begin
    pos_sum = (CNT_W + 1)'(oldest_next) + (CNT_W + 1)'(occ_after);
    if (32'(pos_sum) >= ENTRIES) pos_sum = pos_sum - (CNT_W + 1)'(ENTRIES);
    pos = pos_sum[IDX_W-1:0];
  end

  // valid bits after an insert: the evicted slot drops, then the new slot is set
  always_comb begin
    valid_next = entry_valid;
    if (evict_c) valid_next[oldest_slot] = 1'b0;
    valid_next[pos] = 1'b1;
  end

  // key store and ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      oldest_slot  <= '0;
      occupancy    <= '0;
      hit_counter  <= '0;
      miss_counter <= '0;
    end else if (cmd.apply) begin
      if (req_op == OP_LOOKUP) begin
        if (hit_any) begin
          if (hit_counter != '1) hit_counter <= hit_counter + TOTAL_W'(1);
        end else begin
          if (miss_counter != '1) miss_counter <= miss_counter + TOTAL_W'(1);
        end
      end else if (insert_new) begin
        entry_valid <= valid_next;
        oldest_slot <= oldest_next;
        occupancy   <= occ_after + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && insert_new) entry_key[pos] <= req_key;
    if (cmd.apply) res_evicted <= evict_c;
  end

  // frame memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.apply && insert_new) frame_mem[pos] <= req_frame;
    if (cmd.apply) frame_rd <= frame_mem[hit_slot];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hit         <= hit_any;
      found_frame <= (req_op == OP_LOOKUP && hit_any) ? frame_rd : '0;
      evicted     <= res_evicted;
      hit_total   <= hit_counter;
      miss_total  <= miss_counter;
    end
  end

endmodule

// ===== hw/rtl/fifo_tlb_lookup_update_core.sv =====
// top level of the fully associative translation buffer with fifo replacement
// depends on ftlb_pkg, ftlb_ctrl, ftlb_datapath
//
// Input channel (in_valid/in_ready) carries one beat per request: operation
// 0 looks up logical_address, 1 inserts logical_address with frame_number.
// Output channel (out_valid/out_ready) returns exactly one beat per request:
// hit, found_frame, evicted and the saturating hit_total and miss_total.
// Config channel (cfg_valid/cfg_ready/cfg_data) sets active_entries, the ring
// size at which inserts start evicting the oldest entry; always ready.
// A new request is taken only after the previous one has gone through the
// controller sequence of accept, tag compare, match encode, update with
// frame memory read, and output load. The next request is taken while a
// result waits in the output register; a further result waits in the finish
// step until the receiver takes the pending one, so a stalled receiver holds
// the block. Reset clears all valid bits, the ring pointer, occupancy and
// counters and sets active_entries to 16; key and frame contents are kept.
module fifo_tlb_lookup_update_core #(
  parameter int ENTRIES    = ftlb_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = ftlb_pkg::KEY_BITS_DEF,
  parameter int FRAME_BITS = ftlb_pkg::FRAME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  logic [KEY_BITS-1:0]          logical_address,
  input  logic [FRAME_BITS-1:0]        frame_number,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ftlb_pkg::CFG_W-1:0]   cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic [FRAME_BITS-1:0]        found_frame,
  output logic                         evicted,
  output logic [ftlb_pkg::TOTAL_W-1:0] hit_total,
  output logic [ftlb_pkg::TOTAL_W-1:0] miss_total
);
  import ftlb_pkg::*;

  ftlb_cmd_t    cmd;
  ftlb_status_t status;

  // sequencer
  ftlb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // storage and arithmetic
  ftlb_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .operation       (operation),
    .logical_address (logical_address),
    .frame_number    (frame_number),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .hit             (hit),
    .found_frame     (found_frame),
    .evicted         (evicted),
    .hit_total       (hit_total),
    .miss_total      (miss_total)
  );

endmodule

// ===== hw/rtl/ftlb_checker.sv =====
// port-level checks of the translation buffer, bound to the top level
// depends on ftlb_pkg and fifo_tlb_lookup_update_core_assert.svh
`include "fifo_tlb_lookup_update_core_assert.svh"

module ftlb_checker #(
  parameter int FRAME_BITS = ftlb_pkg::FRAME_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         hit,
  input logic [FRAME_BITS-1:0]        found_frame,
  input logic                         evicted,
  input logic [ftlb_pkg::TOTAL_W-1:0] hit_total,
  input logic [ftlb_pkg::TOTAL_W-1:0] miss_total
);
  import ftlb_pkg::*;

  // a taken request keeps the input closed while it is worked on
  `FTLB_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // an eviction only comes from an insert of a missing key
  `FTLB_ASSERT_NOW(a_evict_no_hit, out_valid && evicted, !hit)

  // a nonzero frame is only returned on a hit
  `FTLB_ASSERT_NOW(a_frame_needs_hit, out_valid && (found_frame != '0), hit)

  // stalled result beat holds
  `FTLB_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
    out_valid && $stable(found_frame) && $stable(hit_total) && $stable(miss_total))

endmodule

bind fifo_tlb_lookup_update_core ftlb_checker #(
  .FRAME_BITS (FRAME_BITS)
) u_ftlb_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .hit         (hit),
  .found_frame (found_frame),
  .evicted     (evicted),
  .hit_total   (hit_total),
  .miss_total  (miss_total)
);
